// ----- design/mmgt_pkg.sv -----
// ----------------------------------------------------------------------------
// mmgt_pkg
// Shared types and codes for the min/max gap tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mmgt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;
  localparam int unsigned CapW   = 7;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TOO_FEW = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     start_new;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CountW-1:0] count_held;
    logic [ValueW-1:0] shortest_span;
    logic [ValueW-1:0] longest_span;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the request
    logic insert;  // clear if asked, shift cells, grab neighbours
    logic finish;  // update gap and extremes, load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic result_busy;  // result register still holds an untaken result
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/mmgt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmgt_ctrl
// Sequencer: accept, insert into the sorted cells, then update and report.
// ----------------------------------------------------------------------------
`default_nettype none

module mmgt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  output logic                   cfg_ready,
  input  wire mmgt_pkg::dp_stat_t stat,
  output mmgt_pkg::dp_cmd_t       cmd
);
  import mmgt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_GAP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_next = S_GAP;
      end
      S_GAP: begin
        // wait here until the result register has room
        if (!stat.result_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/mmgt_dp.sv -----
// ----------------------------------------------------------------------------
// mmgt_dp
// Sorted cell array with parallel compare and shift, gap and extreme tracking,
// capacity register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmgt_dp #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mmgt_pkg::item_t     item,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [6:0]          cfg_data,
  input  wire mmgt_pkg::dp_cmd_t   cmd,
  output mmgt_pkg::dp_stat_t       stat,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output mmgt_pkg::result_t        result
);
  import mmgt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WW = ((CW > CapW) ? CW : CapW) + 1;

  logic [ValueW-1:0] cells [MAX_ENTRIES];
  logic [CW-1:0]     count;
  logic [ValueW-1:0] least_gap;
  logic [ValueW-1:0] least_value;
  logic [ValueW-1:0] greatest_value;
  logic [CapW-1:0]   capacity;

  logic [ValueW-1:0] x;
  logic              start_new;
  logic              rejected;
  logic              was_empty;
  logic              has_prev;
  logic              has_next;
  logic [ValueW-1:0] prev_val;
  logic [ValueW-1:0] next_val;

  logic [CW-1:0]     count_eff;
  logic [WW-1:0]     cap_eff;
  logic              reject_now;
  logic [MAX_ENTRIES-1:0] ge;
  logic [MAX_ENTRIES-1:0] sel_prev;
  logic [MAX_ENTRIES-1:0] sel_next;
  logic [ValueW-1:0] prev_mux;
  logic [ValueW-1:0] next_mux;

  assign count_eff = start_new ? '0 : count;
  assign cap_eff   = (WW'(capacity) > WW'(MAX_ENTRIES)) ? WW'(MAX_ENTRIES) : WW'(capacity);
  assign reject_now = (WW'(count_eff) >= cap_eff);

  // each cell flags whether the new value goes at or before it
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ge[i] = ((CW'(i) < count_eff) && ($signed(cells[i]) > $signed(x)))
              || (CW'(i) == count_eff);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i == MAX_ENTRIES - 1) begin
        sel_prev[i] = !ge[i] && (CW'(i) < count_eff);
      end else begin
        sel_prev[i] = !ge[i] && ge[i+1];
      end
      if (i == 0) begin
        sel_next[i] = ge[i] && (CW'(i) < count_eff);
      end else begin
        sel_next[i] = ge[i] && !ge[i-1] && (CW'(i) < count_eff);
      end
    end
    prev_mux = '0;
    next_mux = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      prev_mux = prev_mux | ({ValueW{sel_prev[i]}} & cells[i]);
      next_mux = next_mux | ({ValueW{sel_next[i]}} & cells[i]);
    end
  end

  // cell shift: past the slot each cell takes its left neighbour, the slot takes the new value
  always_ff @(posedge clk) begin
    if (cmd.insert && !reject_now) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (ge[i]) begin
          if (i > 0 && ge[i-(i > 0 ? 1 : 0)] && i != 0) begin
            cells[i] <= cells[i-1];
          end else begin
            cells[i] <= x;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x         <= item.value;
      start_new <= item.start_new;
    end
    if (cmd.insert) begin
      rejected  <= reject_now;
      was_empty <= (count_eff == '0);
      has_prev  <= !ge[0];
      has_next  <= |sel_next;
      prev_val  <= prev_mux;
      next_val  <= next_mux;
    end
  end

  // gap and extremes after the insert
  logic [ValueW-1:0] gap_lo;
  logic [ValueW-1:0] gap_hi;
  logic [ValueW-1:0] gap_new;
  logic [ValueW-1:0] lo_new;
  logic [ValueW-1:0] hi_new;
  logic [ValueW-1:0] gap_out;
  logic [ValueW-1:0] lo_out;
  logic [ValueW-1:0] hi_out;

  always_comb begin
    gap_lo  = x - prev_val;
    gap_hi  = next_val - x;
    gap_new = least_gap;
    if (has_prev && (gap_lo < gap_new)) begin
      gap_new = gap_lo;
    end
    if (has_next && (gap_hi < gap_new)) begin
      gap_new = gap_hi;
    end
    lo_new = (was_empty || !has_prev) ? x : least_value;
    hi_new = (was_empty || !has_next) ? x : greatest_value;
    gap_out = rejected ? least_gap      : gap_new;
    lo_out  = rejected ? least_value    : lo_new;
    hi_out  = rejected ? greatest_value : hi_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      least_gap      <= '1;
      least_value    <= '0;
      greatest_value <= '0;
      capacity       <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (cmd.insert) begin
        if (start_new) begin
          least_gap      <= '1;
          least_value    <= '0;
          greatest_value <= '0;
        end
        if (!reject_now) begin
          count <= count_eff + CW'(1);
        end else begin
          count <= count_eff;
        end
      end
      if (cmd.finish) begin
        least_gap      <= gap_out;
        least_value    <= lo_out;
        greatest_value <= hi_out;
        result_valid   <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.count_held <= CountW'(count);
      if (rejected) begin
        result.status <= STATUS_FULL;
      end else if (count < CW'(2)) begin
        result.status <= STATUS_TOO_FEW;
      end else begin
        result.status <= STATUS_OK;
      end
      if (count < CW'(2)) begin
        result.shortest_span <= '0;
        result.longest_span  <= '0;
      end else begin
        result.shortest_span <= gap_out;
        result.longest_span  <= hi_out - lo_out;
      end
    end
  end

  assign stat.result_busy = result_valid && result_stall;

endmodule

`default_nettype wire

// ----- design/min_max_gap_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// min_max_gap_tracker_unit
// Bounded sorted set of signed 32-bit values reporting minimum neighbour gap
// and full span for every request.
// ----------------------------------------------------------------------------
// Each request passes through these steps: the accepting edge captures it, the
// next edge has all cells compare against the new value in parallel and shift
// to open its slot, and a last step folds the two new neighbour gaps into the
// running minimum and loads the result register once that register has room.
// The request port stalls until that last step, so a new request is taken only
// after the last one is through; a result left untaken holds the next request
// in its last step. The capacity register is written through the cfg port while
// idle.
`default_nettype none

module min_max_gap_tracker_unit #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire mmgt_pkg::item_t   item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [6:0]        cfg_data,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output mmgt_pkg::result_t      result
);
  import mmgt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mmgt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cfg_ready  (cfg_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mmgt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- design/mmgt_checker.sv -----
// ----------------------------------------------------------------------------
// mmgt_checker
// Port-level checks on the gap tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module mmgt_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire mmgt_pkg::result_t result
);
  import mmgt_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("request taken while another is in flight");

  a_too_few_spans: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.count_held < 7'd2) |->
      (result.shortest_span == '0) && (result.longest_span == '0))
    else $error("spans nonzero with fewer than two values");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != STATUS_FULL) |->
      ((result.status == STATUS_TOO_FEW) == (result.count_held < 7'd2)))
    else $error("status disagrees with count");

endmodule

bind min_max_gap_tracker_unit mmgt_checker u_mmgt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ----- tb/sv/min_max_gap_tracker_unit_tb.sv -----
// ----------------------------------------------------------------------------
// min_max_gap_tracker_unit_tb
// Self-checking bench for the gap tracker: a directed table of requests, then
// random runs of requests, checked field by field against a sorted-set
// predictor, across several capacity settings, mostly with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_gap_tracker_unit_tb;
  import mmgt_pkg::*;

  localparam int unsigned MaxEntries = 64;

  typedef struct {
    logic signed [31:0] value;
    logic               start_new;
    logic               typed;    // expected result given in the row
    result_t            res;
  } row_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [6:0] cfg_data;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  min_max_gap_tracker_unit #(.MAX_ENTRIES(MaxEntries)) u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // predictor state
  logic [31:0] set_vals[$];
  logic [31:0] min_gap;
  logic [6:0]  cap_reg;
  result_t     pending_results[$];
  int          fail_count;
  int          results_seen;
  int          full_seen;
  bit          quiet;          // no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic result_t predict_gap_result(logic [31:0] x, logic sn);
    result_t r;
    int      cap;
    int      pos;
    logic [31:0] g;
    cap = (cap_reg > MaxEntries) ? MaxEntries : cap_reg;
    if (sn) begin
      set_vals.delete();
      min_gap = '1;
    end
    if (set_vals.size() >= cap) begin
      r.status = STATUS_FULL;
    end else begin
      pos = 0;
      while (pos < set_vals.size() && $signed(set_vals[pos]) <= $signed(x)) pos++;
      if (pos > 0) begin
        g = x - set_vals[pos-1];
        if (g < min_gap) min_gap = g;
      end
      if (pos < set_vals.size()) begin
        g = set_vals[pos] - x;
        if (g < min_gap) min_gap = g;
      end
      set_vals.insert(pos, x);
      r.status = (set_vals.size() < 2) ? STATUS_TOO_FEW : STATUS_OK;
    end
    r.count_held = 7'(set_vals.size());
    if (set_vals.size() >= 2) begin
      r.shortest_span = min_gap;
      r.longest_span  = set_vals[$] - set_vals[0];
    end else begin
      r.shortest_span = '0;
      r.longest_span  = '0;
    end
    return r;
  endfunction

  function automatic row_t mk(logic signed [31:0] v, logic sn);
    row_t r;
    r.value = v; r.start_new = sn; r.typed = 1'b0; r.res = '0;
    return r;
  endfunction

  function automatic row_t mkx(logic signed [31:0] v, logic sn, logic [1:0] st,
                               int cnt, logic [31:0] sh, logic [31:0] lo);
    row_t r;
    r.value = v; r.start_new = sn; r.typed = 1'b1;
    r.res.status = st; r.res.count_held = 7'(cnt);
    r.res.shortest_span = sh; r.res.longest_span = lo;
    return r;
  endfunction

  // handshake only; valid stays up after acceptance until the next request
  // or an idle cycle takes it down at a falling edge
  task automatic drive_item(logic [31:0] v, logic sn);
    while (!quiet && $urandom_range(99) < 12) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid     <= 1'b1;
    item.value     <= v;
    item.start_new <= sn;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_request(logic [31:0] v, logic sn);
    result_t p;
    drive_item(v, sn);
    p = predict_gap_result(v, sn);
    if (p.status == STATUS_FULL) full_seen++;
    pending_results.insert(pending_results.size(), p);
  endtask

  task automatic drain_and_configure(logic [6:0] cap);
    int guard;
    guard = 0;
    item_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall, check each accepted result
  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= !quiet && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status); fail_count++;
        end
        if (result.count_held !== e.count_held) begin
          $error("count_held exp %0d got %0d", e.count_held, result.count_held);
          fail_count++;
        end
        if (result.shortest_span !== e.shortest_span) begin
          $error("shortest_span exp %h got %h", e.shortest_span, result.shortest_span);
          fail_count++;
        end
        if (result.longest_span !== e.longest_span) begin
          $error("longest_span exp %h got %h", e.longest_span, result.longest_span);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t    dir_rows[$];
    result_t p;
    int      n;
    int      guard;
    int      run_len;
    logic [6:0] caps[6];
    logic [31:0] v;
    rst = 1'b1; item_valid = 1'b0; item = '0; cfg_valid = 1'b0; cfg_data = '0;
    quiet = 1'b0;
    fail_count = 0; results_seen = 0; full_seen = 0;
    min_gap = '1; cap_reg = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero capacity after reset: everything rejected
    dir_rows.insert(dir_rows.size(), mkx(32'sd5, 1'b0, STATUS_FULL, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), mkx(-32'sd7, 1'b1, STATUS_FULL, 0, 0, 0));
    foreach (dir_rows[i]) begin
      p = predict_gap_result(dir_rows[i].value, dir_rows[i].start_new);
      if (p != dir_rows[i].res) begin
        $error("directed row %0d disagrees with predictor", i); fail_count++;
      end
      pending_results.insert(pending_results.size(), dir_rows[i].res);
      full_seen++;
      drive_item(dir_rows[i].value, dir_rows[i].start_new);
    end

    // capacity above the store acts as the store size
    drain_and_configure(7'd127);
    dir_rows.delete();
    dir_rows.insert(dir_rows.size(), mkx(32'h7fffffff, 1'b1, STATUS_TOO_FEW, 1, 0, 0));
    dir_rows.insert(dir_rows.size(),
                    mkx(32'h80000000, 1'b0, STATUS_OK, 2, 32'hffffffff, 32'hffffffff));
    dir_rows.insert(dir_rows.size(), mk(32'sd0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk(32'sd0, 1'b0));      // equal values give a zero gap
    dir_rows.insert(dir_rows.size(), mk(-32'sd1, 1'b0));
    dir_rows.insert(dir_rows.size(), mkx(32'sd9, 1'b1, STATUS_TOO_FEW, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), mk(32'sd9, 1'b0));
    dir_rows.insert(dir_rows.size(), mk(32'sd3, 1'b0));
    dir_rows.insert(dir_rows.size(), mk(32'sd100, 1'b0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        p = predict_gap_result(dir_rows[i].value, dir_rows[i].start_new);
        if (p != dir_rows[i].res) begin
          $error("directed row %0d disagrees with predictor", i); fail_count++;
        end
        pending_results.insert(pending_results.size(), dir_rows[i].res);
        drive_item(dir_rows[i].value, dir_rows[i].start_new);
      end else begin
        send_request(dir_rows[i].value, dir_rows[i].start_new);
      end
    end

    // capacity lowered below the count: rejected, set kept
    drain_and_configure(7'd2);
    send_request(32'sd1, 1'b0);
    send_request(32'sd1, 1'b1);
    send_request(32'sd2, 1'b0);
    send_request(32'sd3, 1'b0);

    // random phases over several capacities, mostly filling runs
    caps = '{7'd64, 7'd1, 7'd5, 7'd16, 7'd70, 7'd3};
    n = 0;
    foreach (caps[c]) begin
      drain_and_configure(caps[c]);
      quiet = (c == 3);
      while (n < (c + 1) * 85) begin
        run_len = $urandom_range(1, (caps[c] > 20) ? 40 : caps[c] + 3);
        for (int k = 0; k < run_len; k++) begin
          case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(20) - 10;
            2: v = {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
            default: v = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
          endcase
          send_request(v, k == 0 ? 1'b1 : ($urandom_range(99) < 3));
          n++;
        end
      end
    end
    quiet = 1'b0;
    item_valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("checked %0d results (%0d rejected adds) over %0d capacity settings",
             results_seen, full_seen, 9);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
